// ----- hw/rtl/fmc_pkg.sv -----
// Package: request/result types and codes for the monotonic-check FIFO.
package fmc_pkg;

	localparam int DEPTH   = 16;
	localparam int VALUE_W = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int PAIR_W  = $clog2(DEPTH);

	localparam logic [1:0] ACT_PUSH  = 2'd0;
	localparam logic [1:0] ACT_POP   = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [1:0]                action;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] popped_value;
		logic [1:0]                status;
		logic [CNT_W-1:0]          entry_count;
		logic                      non_decreasing;
		logic                      non_increasing;
		logic                      is_sorted;
	} rsp_t;

endpackage

// ----- hw/rtl/fifo_with_monotonic_check.sv -----
// Top level: bounded FIFO with running non-decreasing/non-increasing check.
// Push, clear, unused-action and refused requests: result strobed in the cycle
// after accept. Pop: accept moves to S_POP, where busy is high while the slot
// RAM's registered read returns the head; the result is strobed on leaving S_POP.
// One request per cycle while busy is low; results cannot stall.
// Reset (async, active low) empties the queue and zeroes pointers and pair
// counts; slot contents are not cleared and need no clearing pass.
module fifo_with_monotonic_check (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  fmc_pkg::req_t request,
	output logic          done,
	output fmc_pkg::rsp_t result
);

	localparam int DEPTH   = fmc_pkg::DEPTH;
	localparam int VALUE_W = fmc_pkg::VALUE_W;
	localparam int PTR_W   = fmc_pkg::PTR_W;
	localparam int CNT_W   = fmc_pkg::CNT_W;
	localparam int PAIR_W  = fmc_pkg::PAIR_W;

	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_POP  = 2'b10
	} state_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		n = (p == LAST_PTR) ? '0 : p + 1'b1;
		return n;
	endfunction

	state_t                    state_q, state_d;
	logic [PTR_W-1:0]          front_q, front_d;
	logic [PTR_W-1:0]          back_q, back_d;
	logic [CNT_W-1:0]          held_q, held_d;
	logic [PAIR_W-1:0]         rise_q, rise_d;
	logic [PAIR_W-1:0]         fall_q, fall_d;
	logic signed [VALUE_W-1:0] last_q, last_d;
	logic                      done_q, done_d;
	fmc_pkg::rsp_t             result_q, result_d;

	logic                      wr_en;
	logic [VALUE_W-1:0]        rd_data_a, rd_data_b;
	logic signed [VALUE_W-1:0] head_val, next_val;
	logic                      accept;

	assign accept   = start && (state_q == S_IDLE);
	assign head_val = $signed(rd_data_a);
	assign next_val = $signed(rd_data_b);
	assign wr_en    = accept && (request.action == fmc_pkg::ACT_PUSH) && (held_q != FULL_CNT);

	fmc_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (back_q),
		.wr_data  (request.value),
		.rd_addr_a(front_q),
		.rd_data_a(rd_data_a),
		.rd_addr_b(next_ptr(front_q)),
		.rd_data_b(rd_data_b)
	);

	always_comb begin
		state_d  = state_q;
		front_d  = front_q;
		back_d   = back_q;
		held_d   = held_q;
		rise_d   = rise_q;
		fall_d   = fall_q;
		last_d   = last_q;
		done_d   = 1'b0;
		result_d = '0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (request.action)
						fmc_pkg::ACT_PUSH: begin
							done_d = 1'b1;
							if (held_q == FULL_CNT) begin
								result_d.status = fmc_pkg::ST_FULL;
							end else begin
								if (held_q != '0) begin
									if (last_q < request.value) begin
										rise_d = rise_q + 1'b1;
									end else if (last_q > request.value) begin
										fall_d = fall_q + 1'b1;
									end
								end
								back_d = next_ptr(back_q);
								last_d = request.value;
								held_d = held_q + 1'b1;
							end
						end
						fmc_pkg::ACT_POP: begin
							if (held_q == '0) begin
								done_d          = 1'b1;
								result_d.status = fmc_pkg::ST_EMPTY;
							end else begin
								state_d = S_POP;
							end
						end
						fmc_pkg::ACT_CLEAR: begin
							done_d  = 1'b1;
							front_d = '0;
							back_d  = '0;
							held_d  = '0;
							rise_d  = '0;
							fall_d  = '0;
							last_d  = '0;
						end
						default: begin
							done_d = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				state_d               = S_IDLE;
				done_d                = 1'b1;
				result_d.popped_value = head_val;
				if (held_q >= CNT_W'(2)) begin
					if (head_val < next_val) begin
						if (rise_q != '0) begin
							rise_d = rise_q - 1'b1;
						end
					end else if (head_val > next_val) begin
						if (fall_q != '0) begin
							fall_d = fall_q - 1'b1;
						end
					end
				end
				front_d = next_ptr(front_q);
				held_d  = held_q - 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		result_d.entry_count    = held_d;
		result_d.non_decreasing = (fall_d == '0);
		result_d.non_increasing = (rise_d == '0);
		result_d.is_sorted      = (fall_d == '0) || (rise_d == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			front_q <= '0;
			back_q  <= '0;
			held_q  <= '0;
			rise_q  <= '0;
			fall_q  <= '0;
			last_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			back_q  <= back_d;
			held_q  <= held_d;
			rise_q  <= rise_d;
			fall_q  <= fall_d;
			last_q  <= last_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
	end

	assign busy   = (state_q == S_POP);
	assign done   = done_q;
	assign result = result_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= FULL_CNT)
		else $error("entry count above depth");

	a_empty_no_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == '0) |-> (rise_q == '0) && (fall_q == '0))
		else $error("pair counts nonzero on empty queue");

	a_busy_no_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result strobe during pop read");

	a_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (request.action == fmc_pkg::ACT_POP) && (held_q != '0)) |=> busy)
		else $error("pop request did not enter read cycle");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("pop result not delivered after read cycle");

endmodule

// ----- hw/rtl/fmc_ram.sv -----
// Generic RAM: one write port, two registered read ports.
module fmc_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic [ADDR_W-1:0] rd_addr_a,
	output logic [WIDTH-1:0]  rd_data_a,
	input  logic [ADDR_W-1:0] rd_addr_b,
	output logic [WIDTH-1:0]  rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the FIFO with running monotonic check.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fmc_pkg::*;

	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 500;
	localparam int RANDOM_REQS = 550;
	localparam int CALM_TAIL   = 100;

	typedef struct {
		req_t req;
		bit   fixed;
		rsp_t want;
	} plan_row_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  start = 1'b0;
	logic  busy;
	logic  done;
	req_t  request = '0;
	rsp_t  result;

	// shadow queue
	logic signed [VALUE_W-1:0] ring [DEPTH];
	logic [PTR_W-1:0]          head = '0;
	logic [PTR_W-1:0]          tail = '0;
	int                        occupancy = 0;
	int                        ups = 0;
	int                        downs = 0;
	logic signed [VALUE_W-1:0] newest = '0;

	rsp_t      pending_results [$];
	plan_row_t plan [$];
	bit        use_fixed = 1'b0;
	rsp_t      fixed_rsp = '0;
	int        mismatches = 0;
	int        stall_cycles = 0;

	fifo_with_monotonic_check u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #1 clk = ~clk;

	task automatic flag_mismatch(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("mismatch: %s", msg);
	endtask

	function automatic void tally_pair(logic signed [VALUE_W-1:0] a,
			logic signed [VALUE_W-1:0] b, bit add);
		if (a < b) begin
			if (add)
				ups++;
			else if (ups > 0)
				ups--;
		end else if (a > b) begin
			if (add)
				downs++;
			else if (downs > 0)
				downs--;
		end
	endfunction

	function automatic rsp_t predict_response(req_t r);
		rsp_t             o;
		logic [PTR_W-1:0] nxt;
		o = '0;
		case (r.action)
			ACT_PUSH: begin
				if (occupancy >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					if (occupancy > 0)
						tally_pair(newest, r.value, 1'b1);
					ring[tail] = r.value;
					tail = tail + 1'b1;
					newest = r.value;
					occupancy++;
				end
			end
			ACT_POP: begin
				if (occupancy == 0) begin
					o.status = ST_EMPTY;
				end else begin
					nxt = head + 1'b1;
					o.popped_value = ring[head];
					if (occupancy >= 2)
						tally_pair(ring[head], ring[nxt], 1'b0);
					head = nxt;
					occupancy--;
				end
			end
			ACT_CLEAR: begin
				head = '0;
				tail = '0;
				occupancy = 0;
				ups = 0;
				downs = 0;
				newest = '0;
			end
			default: ;
		endcase
		o.status = o.status;
		o.entry_count = CNT_W'(occupancy);
		o.non_decreasing = (downs == 0);
		o.non_increasing = (ups == 0);
		o.is_sorted = (downs == 0) || (ups == 0);
		return o;
	endfunction

	function automatic rsp_t rsp(logic signed [VALUE_W-1:0] pv, logic [1:0] st,
			int cnt, bit nd, bit ni, bit srt);
		rsp_t o;
		o.popped_value = pv;
		o.status = st;
		o.entry_count = CNT_W'(cnt);
		o.non_decreasing = nd;
		o.non_increasing = ni;
		o.is_sorted = srt;
		return o;
	endfunction

	function automatic void add_row(logic [1:0] act, logic signed [VALUE_W-1:0] v,
			bit fixed = 1'b0, rsp_t want = '0);
		plan_row_t row;
		row.req.action = act;
		row.req.value = v;
		row.fixed = fixed;
		row.want = want;
		plan.push_back(row);
	endfunction

	task automatic issue(req_t r, bit fixed, rsp_t want);
		request <= r;
		start <= 1'b1;
		use_fixed = fixed;
		fixed_rsp = want;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	always @(posedge clk) begin : scoreboard
		rsp_t p;
		rsp_t w;
		if (arst_n) begin
			if (start && !busy) begin
				p = predict_response(request);
				pending_results.push_back(use_fixed ? fixed_rsp : p);
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					flag_mismatch("result with no request pending");
				end else begin
					w = pending_results.pop_front();
					if (result.popped_value !== w.popped_value)
						flag_mismatch($sformatf("popped_value got %0d want %0d",
							result.popped_value, w.popped_value));
					if (result.status !== w.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							result.status, w.status));
					if (result.entry_count !== w.entry_count)
						flag_mismatch($sformatf("entry_count got %0d want %0d",
							result.entry_count, w.entry_count));
					if (result.non_decreasing !== w.non_decreasing)
						flag_mismatch($sformatf("non_decreasing got %0b want %0b",
							result.non_decreasing, w.non_decreasing));
					if (result.non_increasing !== w.non_increasing)
						flag_mismatch($sformatf("non_increasing got %0b want %0b",
							result.non_increasing, w.non_increasing));
					if (result.is_sorted !== w.is_sorted)
						flag_mismatch($sformatf("is_sorted got %0b want %0b",
							result.is_sorted, w.is_sorted));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic signed [VALUE_W-1:0] vmin;
		logic signed [VALUE_W-1:0] vmax;
		logic [VALUE_W-1:0]        step_v;
		req_t                      r;
		int                        sent;
		int                        push_pct;
		int                        vmode;
		int                        seg_len;
		int                        roll;
		int                        cur;

		vmin = {1'b1, {(VALUE_W-1){1'b0}}};
		vmax = {1'b0, {(VALUE_W-1){1'b1}}};

		add_row(ACT_POP, 0, 1'b1, rsp(0, ST_EMPTY, 0, 1, 1, 1));
		add_row(ACT_PUSH, vmax, 1'b1, rsp(0, ST_OK, 1, 1, 1, 1));
		add_row(ACT_PUSH, vmin, 1'b1, rsp(0, ST_OK, 2, 0, 1, 1));
		add_row(ACT_PUSH, vmin);
		add_row(ACT_UNUSED, 123);
		add_row(ACT_PUSH, 5);
		add_row(ACT_POP, -1);
		add_row(ACT_CLEAR, 7, 1'b1, rsp(0, ST_OK, 0, 1, 1, 1));
		for (int i = 0; i < DEPTH; i++) begin
			step_v = 32'h8000_0000 + 32'(i) * 32'd286331153;
			add_row(ACT_PUSH, step_v);
		end
		add_row(ACT_PUSH, 0, 1'b1, rsp(0, ST_FULL, DEPTH, 1, 0, 1));
		add_row(ACT_POP, 0);
		add_row(ACT_CLEAR, vmax, 1'b1, rsp(0, ST_OK, 0, 1, 1, 1));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (plan[i])
			issue(plan[i].req, plan[i].fixed, plan[i].want);

		sent = 0;
		while (sent < RANDOM_REQS) begin
			case ($urandom_range(0, 3))
				0: push_pct = 25;
				1: push_pct = 50;
				2: push_pct = 70;
				default: push_pct = 90;
			endcase
			vmode = $urandom_range(0, 3);
			seg_len = $urandom_range(10, 30);
			cur = $urandom();
			for (int k = 0; k < seg_len && sent < RANDOM_REQS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 2)
					r.action = ACT_CLEAR;
				else if (roll < 2 + push_pct)
					r.action = ACT_PUSH;
				else
					r.action = ACT_POP;
				case (vmode)
					0: cur = cur + $urandom_range(0, 3);
					1: cur = cur - $urandom_range(0, 3);
					2: cur = $urandom_range(0, 7) - 4;
					default: begin
						roll = $urandom_range(0, 9);
						cur = (roll == 0) ? vmin : (roll == 1) ? vmax : $urandom();
					end
				endcase
				r.value = (r.action == ACT_PUSH) ? cur : $urandom();
				if (sent < RANDOM_REQS - CALM_TAIL && $urandom_range(0, 3) == 0)
					pause($urandom_range(1, 6));
				issue(r, 1'b0, '0);
				sent++;
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/fmc_pkg.sv
hw/rtl/fmc_ram.sv
hw/rtl/fifo_with_monotonic_check.sv
tb/testbench.sv
